// ----- src/etsud_pkg.sv -----
`default_nettype none

package etsud_pkg;

    // 86400 = 675 << 7
    localparam int          DAY_LOW_BITS = 7;
    localparam logic [9:0]  DAY_ODD      = 10'd675;
    localparam int          DAY_FRAC     = 35;
    localparam logic [25:0] DAY_RECIP    = 26'((64'd1 << DAY_FRAC) / 64'd675);

    // 3600 = 225 << 4
    localparam int          HOUR_LOW_BITS = 4;
    localparam logic [7:0]  HOUR_ODD      = 8'd225;
    localparam int          HOUR_FRAC     = 16;
    localparam logic [8:0]  HOUR_RECIP    = 9'((64'd1 << HOUR_FRAC) / 64'd225);

    // 60 = 15 << 2
    localparam int          MIN_LOW_BITS = 2;
    localparam logic [3:0]  MIN_ODD      = 4'd15;
    localparam int          MIN_FRAC     = 12;
    localparam logic [8:0]  MIN_RECIP    = 9'((64'd1 << MIN_FRAC) / 64'd15);

    localparam logic [2:0]  WDAY_DIV   = 3'd7;
    localparam logic [2:0]  EPOCH_WDAY = 3'd4;
    localparam int          WDAY_FRAC  = 19;
    localparam logic [16:0] WDAY_RECIP = 17'((64'd1 << WDAY_FRAC) / 64'd7);

    // day count moved to march 1 of year 0
    localparam logic [19:0] MARCH0_OFFSET = 20'(719527 - (31 + 28));
    localparam logic [19:0] YEAR_BIAS     = 20'd2;
    localparam logic [8:0]  YEAR_SCALE    = 9'd400;
    localparam logic [17:0] DAYS_400Y     = 18'd146097;
    localparam int          YEAR_FRAC     = 32;
    localparam logic [23:0] YEAR_RECIP    = 24'((64'd400 << YEAR_FRAC) / 64'd146097);

    // x / 25 == (x * 41) >> 10 for x below 1024
    localparam logic [5:0]  CENT_MUL  = 6'd41;
    localparam int          CENT_FRAC = 10;
    localparam logic [6:0]  CENTURY   = 7'd100;
    localparam logic [8:0]  YEAR_DAYS = 9'd365;

    // first day of each march-based month, month 1 is march
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };
    localparam logic [3:0] MONTH_JAN   = 4'd11;
    localparam logic [3:0] MONTH_WRAP  = 4'd10;
    localparam logic [3:0] MONTH_SHIFT = 4'd2;

    localparam int SPLIT_STAGES = 2;
    localparam int DATE_STAGES  = 8;
    localparam int CLOCK_PAD    = 4;
    localparam int WDAY_PAD     = 5;
    localparam int LATENCY      = SPLIT_STAGES + DATE_STAGES;

    typedef struct packed {
        logic [5:0] second_of_minute;
        logic [5:0] minute_of_hour;
        logic [4:0] hour_of_day;
    } time_of_day_t;

    typedef struct packed {
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [11:0] calendar_year;
        logic [2:0]  day_of_week;
    } date_t;

endpackage

`default_nettype wire

// ----- src/etsud_if.sv -----
`default_nettype none

interface etsud_stamp_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface etsud_date_if;
    logic        valid;
    logic        ready;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] calendar_year;
    logic [2:0]  day_of_week;

    modport source (
        output valid, output second_of_minute, output minute_of_hour,
        output hour_of_day, output day_of_month, output month_number,
        output calendar_year, output day_of_week, input ready
    );
    modport sink (
        input valid, input second_of_minute, input minute_of_hour,
        input hour_of_day, input day_of_month, input month_number,
        input calendar_year, input day_of_week, output ready
    );
endinterface

`default_nettype wire

// ----- src/epoch_seconds_to_utc_date.sv -----
// throughput: one word per cycle, set by a ten-stage pipeline; the whole
// pipeline holds while the result word waits to be taken
// reset: rst_n clears the stage valid bits only; the pipeline comes up empty
`default_nettype none

module epoch_seconds_to_utc_date (
    input  wire logic   clk,
    input  wire logic   rst_n,
    etsud_stamp_if.sink stamp,
    etsud_date_if.source date
);

    localparam int Last = etsud_pkg::LATENCY - 1;

    logic [Last:0] valid_reg, valid_next;
    logic          adv;

    logic [15:0] days;
    logic [16:0] sec_of_day;
    etsud_pkg::time_of_day_t tod;
    etsud_pkg::date_t        cal;

    assign adv         = !valid_reg[Last] || date.ready;
    assign stamp.ready = adv;
    assign valid_next  = {valid_reg[Last-1:0], stamp.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    etsud_day_split u_split (
        .clk           (clk),
        .adv           (adv),
        .epoch_seconds (stamp.epoch_seconds),
        .days          (days),
        .sec_of_day    (sec_of_day)
    );

    etsud_clock u_clock (
        .clk        (clk),
        .adv        (adv),
        .sec_of_day (sec_of_day),
        .tod        (tod)
    );

    etsud_date u_date (
        .clk  (clk),
        .adv  (adv),
        .days (days),
        .date (cal)
    );

    assign date.valid            = valid_reg[Last];
    assign date.second_of_minute = tod.second_of_minute;
    assign date.minute_of_hour   = tod.minute_of_hour;
    assign date.hour_of_day      = tod.hour_of_day;
    assign date.day_of_month     = cal.day_of_month;
    assign date.month_number     = cal.month_number;
    assign date.calendar_year    = cal.calendar_year;
    assign date.day_of_week      = cal.day_of_week;

endmodule

`default_nettype wire

// ----- src/etsud_day_split.sv -----
`default_nettype none

module etsud_day_split (
    input  wire logic        clk,
    input  wire logic        adv,
    input  wire logic [31:0] epoch_seconds,
    output logic [15:0]      days,
    output logic [16:0]      sec_of_day
);

    logic [24:0] coarse;
    logic [50:0] day_prod;

    logic [15:0] q0_reg, q0_next;
    logic [24:0] coarse_reg;
    logic [6:0]  low_reg;

    logic [25:0] back;
    logic [25:0] diff;
    logic [10:0] rem;
    logic [15:0] days_reg, days_next;
    logic [9:0]  rem_reg, rem_next;
    logic [6:0]  low2_reg;

    assign coarse   = epoch_seconds[31:etsud_pkg::DAY_LOW_BITS];
    assign day_prod = 51'(coarse) * 51'(etsud_pkg::DAY_RECIP);
    assign q0_next  = day_prod[etsud_pkg::DAY_FRAC +: 16];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q0_reg     <= q0_next;
            coarse_reg <= coarse;
            low_reg    <= epoch_seconds[etsud_pkg::DAY_LOW_BITS-1:0];
        end
    end

    // estimate is low by at most one
    assign back = 26'(q0_reg) * 26'(etsud_pkg::DAY_ODD);
    assign diff = {1'b0, coarse_reg} - back;
    assign rem  = diff[10:0];

    always_comb
    begin
        if (rem >= 11'(etsud_pkg::DAY_ODD))
        begin
            days_next = q0_reg + 16'd1;
            rem_next  = 10'(rem - 11'(etsud_pkg::DAY_ODD));
        end
        else
        begin
            days_next = q0_reg;
            rem_next  = rem[9:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            days_reg <= days_next;
            rem_reg  <= rem_next;
            low2_reg <= low_reg;
        end
    end

    assign days       = days_reg;
    assign sec_of_day = {rem_reg, low2_reg};

endmodule

`default_nettype wire

// ----- src/etsud_clock.sv -----
`default_nettype none

module etsud_clock (
    input  wire logic                   clk,
    input  wire logic                   adv,
    input  wire logic [16:0]            sec_of_day,
    output etsud_pkg::time_of_day_t     tod
);

    logic [12:0] hy;
    logic [21:0] hprod;
    logic [4:0]  h0_reg, h0_next;
    logic [16:0] sod_reg;

    logic [12:0] hy2;
    logic [12:0] hback;
    logic [12:0] hdiff;
    logic [8:0]  hrem;
    logic [4:0]  hour_reg, hour_next;
    logic [11:0] soh_reg, soh_next;

    logic [9:0]  mz;
    logic [17:0] mprod;
    logic [5:0]  m0_reg, m0_next;
    logic [11:0] soh2_reg;
    logic [4:0]  hour2_reg;

    logic [9:0]  mz2;
    logic [9:0]  mback;
    logic [9:0]  mdiff;
    logic [4:0]  mrem;
    etsud_pkg::time_of_day_t tod_reg, tod_next;

    etsud_pkg::time_of_day_t pad_reg [etsud_pkg::CLOCK_PAD];

    assign hy      = sec_of_day[16:etsud_pkg::HOUR_LOW_BITS];
    assign hprod   = 22'(hy) * 22'(etsud_pkg::HOUR_RECIP);
    assign h0_next = hprod[etsud_pkg::HOUR_FRAC +: 5];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h0_reg  <= h0_next;
            sod_reg <= sec_of_day;
        end
    end

    assign hy2   = sod_reg[16:etsud_pkg::HOUR_LOW_BITS];
    assign hback = 13'(h0_reg) * 13'(etsud_pkg::HOUR_ODD);
    assign hdiff = hy2 - hback;
    assign hrem  = hdiff[8:0];

    always_comb
    begin
        if (hrem >= 9'(etsud_pkg::HOUR_ODD))
        begin
            hour_next = h0_reg + 5'd1;
            soh_next  = {8'(hrem - 9'(etsud_pkg::HOUR_ODD)),
                         sod_reg[etsud_pkg::HOUR_LOW_BITS-1:0]};
        end
        else
        begin
            hour_next = h0_reg;
            soh_next  = {hrem[7:0], sod_reg[etsud_pkg::HOUR_LOW_BITS-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hour_reg <= hour_next;
            soh_reg  <= soh_next;
        end
    end

    assign mz      = soh_reg[11:etsud_pkg::MIN_LOW_BITS];
    assign mprod   = 18'(mz) * 18'(etsud_pkg::MIN_RECIP);
    assign m0_next = mprod[etsud_pkg::MIN_FRAC +: 6];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m0_reg    <= m0_next;
            soh2_reg  <= soh_reg;
            hour2_reg <= hour_reg;
        end
    end

    assign mz2   = soh2_reg[11:etsud_pkg::MIN_LOW_BITS];
    assign mback = 10'(m0_reg) * 10'(etsud_pkg::MIN_ODD);
    assign mdiff = mz2 - mback;
    assign mrem  = mdiff[4:0];

    always_comb
    begin
        tod_next.hour_of_day = hour2_reg;
        if (mrem >= 5'(etsud_pkg::MIN_ODD))
        begin
            tod_next.minute_of_hour   = m0_reg + 6'd1;
            tod_next.second_of_minute = {4'(mrem - 5'(etsud_pkg::MIN_ODD)),
                                         soh2_reg[etsud_pkg::MIN_LOW_BITS-1:0]};
        end
        else
        begin
            tod_next.minute_of_hour   = m0_reg;
            tod_next.second_of_minute = {mrem[3:0],
                                         soh2_reg[etsud_pkg::MIN_LOW_BITS-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tod_reg <= tod_next;
        end
    end

    // align with the date path
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pad_reg[0] <= tod_reg;
            for (int i = 1; i < etsud_pkg::CLOCK_PAD; i++)
            begin
                pad_reg[i] <= pad_reg[i-1];
            end
        end
    end

    assign tod = pad_reg[etsud_pkg::CLOCK_PAD-1];

endmodule

`default_nettype wire

// ----- src/etsud_date.sv -----
`default_nettype none

module etsud_date (
    input  wire logic        clk,
    input  wire logic        adv,
    input  wire logic [15:0] days,
    output etsud_pkg::date_t date
);

    // weekday path
    logic [16:0] ww;
    logic [33:0] wprod;
    logic [12:0] wq0_reg, wq0_next;
    logic [16:0] ww_reg;
    logic [15:0] wback;
    logic [16:0] wdiff;
    logic [3:0]  wrem;
    logic [2:0]  wday_reg, wday_next;
    logic [2:0]  wpad_reg [etsud_pkg::WDAY_PAD];

    // year estimate
    logic [19:0] d1;
    logic [19:0] e1;
    logic [43:0] yprod;
    logic [11:0] yq0_reg, yq0_next;
    logic [19:0] e_reg;
    logic [19:0] d_reg;

    logic [29:0] mq_reg, mq_next;
    logic [29:0] t_reg, t_next;
    logic [11:0] yq1_reg;
    logic [19:0] d2_reg;

    logic [29:0] yrr;
    logic [11:0] yest_reg, yest_next;
    logic [19:0] d3_reg;

    // days before year
    logic [15:0] cprod;
    logic [13:0] qprod;
    logic [5:0]  q100_reg, q100_next;
    logic [3:0]  q400_reg, q400_next;
    logic [20:0] y365_reg, y365_next;
    logic [11:0] yest2_reg;
    logic [19:0] d4_reg;

    logic [12:0] cent_back;
    logic [20:0] dby_reg, dby_next;
    logic        leap_reg, leap_next;
    logic [11:0] yest3_reg;
    logic [19:0] d5_reg;

    logic signed [21:0] yd;
    logic signed [21:0] yd_fix;
    logic [8:0]  yday_reg, yday_next;
    logic [11:0] year_reg, year_next;

    logic [3:0]  mon_reg, mon_next;
    logic [8:0]  yday2_reg;
    logic [11:0] year2_reg;

    logic [3:0]  mon_idx;
    logic [8:0]  mday_full;
    etsud_pkg::date_t out_reg, out_next;

    // weekday: (days + 4) mod 7
    assign ww       = 17'(days) + 17'(etsud_pkg::EPOCH_WDAY);
    assign wprod    = 34'(ww) * 34'(etsud_pkg::WDAY_RECIP);
    assign wq0_next = wprod[etsud_pkg::WDAY_FRAC +: 13];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wq0_reg <= wq0_next;
            ww_reg  <= ww;
        end
    end

    assign wback = 16'(wq0_reg) * 16'(etsud_pkg::WDAY_DIV);
    assign wdiff = ww_reg - 17'(wback);
    assign wrem  = wdiff[3:0];

    always_comb
    begin
        if (wrem >= 4'(etsud_pkg::WDAY_DIV))
        begin
            wday_next = 3'(wrem - 4'(etsud_pkg::WDAY_DIV));
        end
        else
        begin
            wday_next = wrem[2:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wday_reg    <= wday_next;
            wpad_reg[0] <= wday_reg;
            for (int i = 1; i < etsud_pkg::WDAY_PAD; i++)
            begin
                wpad_reg[i] <= wpad_reg[i-1];
            end
        end
    end

    // year = (d + 2) * 400 / 146097
    assign d1       = 20'(days) + etsud_pkg::MARCH0_OFFSET;
    assign e1       = d1 + etsud_pkg::YEAR_BIAS;
    assign yprod    = 44'(e1) * 44'(etsud_pkg::YEAR_RECIP);
    assign yq0_next = yprod[etsud_pkg::YEAR_FRAC +: 12];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yq0_reg <= yq0_next;
            e_reg   <= e1;
            d_reg   <= d1;
        end
    end

    assign mq_next = 30'(yq0_reg) * 30'(etsud_pkg::DAYS_400Y);
    assign t_next  = 30'(e_reg) * 30'(etsud_pkg::YEAR_SCALE);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mq_reg  <= mq_next;
            t_reg   <= t_next;
            yq1_reg <= yq0_reg;
            d2_reg  <= d_reg;
        end
    end

    assign yrr = t_reg - mq_reg;

    always_comb
    begin
        if (yrr >= 30'(etsud_pkg::DAYS_400Y))
        begin
            yest_next = yq1_reg + 12'd1;
        end
        else
        begin
            yest_next = yq1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yest_reg <= yest_next;
            d3_reg   <= d2_reg;
        end
    end

    assign cprod     = 16'(yest_reg[11:2]) * 16'(etsud_pkg::CENT_MUL);
    assign qprod     = 14'(yest_reg[11:4]) * 14'(etsud_pkg::CENT_MUL);
    assign q100_next = cprod[etsud_pkg::CENT_FRAC +: 6];
    assign q400_next = qprod[etsud_pkg::CENT_FRAC +: 4];
    assign y365_next = 21'(yest_reg) * 21'(etsud_pkg::YEAR_DAYS);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q100_reg  <= q100_next;
            q400_reg  <= q400_next;
            y365_reg  <= y365_next;
            yest2_reg <= yest_reg;
            d4_reg    <= d3_reg;
        end
    end

    assign cent_back = 13'(q100_reg) * 13'(etsud_pkg::CENTURY);
    assign dby_next  = y365_reg + 21'(yest2_reg[11:2]) - 21'(q100_reg) + 21'(q400_reg);
    assign leap_next = (yest2_reg[1:0] == 2'd0)
                    && ((13'(yest2_reg) != cent_back) || (q100_reg[1:0] == 2'd0));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dby_reg   <= dby_next;
            leap_reg  <= leap_next;
            yest3_reg <= yest2_reg;
            d5_reg    <= d4_reg;
        end
    end

    // estimate one year high: step back into the previous year
    assign yd     = signed'(22'(d5_reg)) - signed'(22'(dby_reg));
    assign yd_fix = yd + signed'(22'(etsud_pkg::YEAR_DAYS)) + signed'(22'(leap_reg));

    always_comb
    begin
        if (yd < 0)
        begin
            yday_next = yd_fix[8:0];
            year_next = yest3_reg - 12'd1;
        end
        else
        begin
            yday_next = yd[8:0];
            year_next = yest3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yday_reg <= yday_next;
            year_reg <= year_next;
        end
    end

    always_comb
    begin
        mon_next = 4'd1;
        for (int k = 1; k < 12; k++)
        begin
            if (yday_reg >= etsud_pkg::MONTH_START[k])
            begin
                mon_next = 4'(k + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mon_reg   <= mon_next;
            yday2_reg <= yday_reg;
            year2_reg <= year_reg;
        end
    end

    assign mon_idx   = mon_reg - 4'd1;
    assign mday_full = yday2_reg - etsud_pkg::MONTH_START[mon_idx] + 9'd1;

    // january and february close the march-based year
    always_comb
    begin
        out_next.day_of_month = mday_full[4:0];
        out_next.day_of_week  = wpad_reg[etsud_pkg::WDAY_PAD-1];
        if (mon_reg >= etsud_pkg::MONTH_JAN)
        begin
            out_next.calendar_year = year2_reg + 12'd1;
            out_next.month_number  = mon_reg - etsud_pkg::MONTH_WRAP;
        end
        else
        begin
            out_next.calendar_year = year2_reg;
            out_next.month_number  = mon_reg + etsud_pkg::MONTH_SHIFT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign date = out_reg;

endmodule

`default_nettype wire

// ----- tb/epoch_seconds_to_utc_date_tb.sv -----
`timescale 1ns / 100ps

module epoch_seconds_to_utc_date_tb;

    localparam longint SECS_PER_DAY   = 86400;
    localparam longint SECS_PER_HOUR  = 3600;
    localparam longint SECS_PER_MIN   = 60;
    localparam longint DAYS_PER_WEEK  = 7;
    localparam longint EPOCH_WEEKDAY  = 4;
    localparam longint JAN_FEB_DAYS   = 31 + 28;
    localparam longint MARCH0_DAYS    = 719527;
    localparam longint DAYS_PER_400Y  = 146097;
    localparam longint YEAR_END_MONTH = 306;
    localparam longint LAST_DAY       = 49710;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS      = 10;
    localparam int PHASE_WORDS      = 400;
    localparam int PRESSURE_WORDS   = 50;

    localparam logic [31:0] EDGE_STAMPS [24] = '{
        32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd2678399, 32'd2678400, 32'd5097599, 32'd5097600,
        32'd68169600, 32'd94694399, 32'd94694400,
        32'd951782400, 32'd951868800, 32'd4107456000, 32'd4107542400,
        32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF
    };

    typedef struct packed {
        logic [5:0]  second_of_minute;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_of_day;
        logic [4:0]  day_of_month;
        logic [3:0]  month_number;
        logic [11:0] calendar_year;
        logic [2:0]  day_of_week;
    } utc_fields_t;

    typedef struct packed {
        logic [31:0] stamp;
        utc_fields_t fields;
    } dated_stamp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        send_valid = 1'b0;
    logic [31:0] send_stamp = '0;
    logic        take_ready = 1'b0;

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    logic        hold_request = 1'b0;
    int          hold_left = 0;

    logic [31:0]  pending_stamps [$];
    dated_stamp_t expected_dates [$];
    int           error_count = 0;
    int           quiet_cycles = 0;

    etsud_stamp_if stamp_ch ();
    etsud_date_if  date_ch ();

    assign stamp_ch.valid         = send_valid;
    assign stamp_ch.epoch_seconds = send_stamp;
    assign date_ch.ready          = take_ready;

    epoch_seconds_to_utc_date i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .stamp (stamp_ch),
        .date  (date_ch)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic utc_fields_t utc_date_of(logic [31:0] stamp_secs);
        longint rem;
        longint days;
        longint shifted;
        longint yr;
        longint yd;
        longint mon;
        longint mday;
        utc_fields_t f;
        rem = stamp_secs;
        days = rem / SECS_PER_DAY;
        rem = rem % SECS_PER_DAY;
        f.hour_of_day = 5'(rem / SECS_PER_HOUR);
        rem = rem % SECS_PER_HOUR;
        f.minute_of_hour = 6'(rem / SECS_PER_MIN);
        f.second_of_minute = 6'(rem % SECS_PER_MIN);
        f.day_of_week = 3'((EPOCH_WEEKDAY + days) % DAYS_PER_WEEK);
        // march-based day count from year 0
        shifted = days - JAN_FEB_DAYS + MARCH0_DAYS;
        yr = (shifted + 2) * 400 / DAYS_PER_400Y;
        yd = shifted - (365 * yr + yr / 4 - yr / 100 + yr / 400);
        if (yd < 0)
        begin
            yd = yd + 365 + (((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) ? 1 : 0);
            yr = yr - 1;
        end
        mon = (yd + 31) * 10 / 306;
        mday = yd - (367 * mon / 12 - 30) + 1;
        // january and february belong to the next calendar year
        if (yd >= YEAR_END_MONTH)
        begin
            yr = yr + 1;
            mon = mon - 10;
        end
        else
        begin
            mon = mon + 2;
        end
        f.day_of_month = 5'(mday);
        f.month_number = 4'(mon);
        f.calendar_year = 12'(yr);
        return f;
    endfunction

    task automatic note_failure(string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR: %s", what);
        end
    endtask

    task automatic queue_random_stamps(int count);
        int     kind;
        longint days;
        longint secs;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(4);
            case (kind)
                0, 1:
                begin
                    secs = $urandom();
                end
                2:
                begin
                    // around midnight
                    days = $urandom_range(LAST_DAY);
                    secs = days * SECS_PER_DAY
                        + ($urandom_range(1) ? $urandom_range(2) : 86399 - $urandom_range(2));
                end
                3:
                begin
                    // late february to early march
                    days = longint'($urandom_range(136)) * 3652425 / 10000
                        + $urandom_range(62, 52);
                    secs = days * SECS_PER_DAY + $urandom_range(86399);
                end
                default:
                begin
                    // around new year
                    days = longint'($urandom_range(136)) * 3652425 / 10000
                        + $urandom_range(367, 361);
                    secs = days * SECS_PER_DAY + $urandom_range(86399);
                end
            endcase
            pending_stamps.push_back(32'(secs));
        end
    endtask

    task automatic wait_drained();
        while (pending_stamps.size() != 0 || send_valid)
        begin
            @(posedge clk);
        end
        while (expected_dates.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            send_stamp <= '0;
        end
        else if (!send_valid || stamp_ch.ready)
        begin
            if (pending_stamps.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                send_stamp <= pending_stamps.pop_front();
                send_valid <= 1'b1;
            end
            else
            begin
                send_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            take_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request)
        begin
            take_ready <= 1'b0;
            hold_left <= LONG_HOLD_CYCLES;
        end
        else
        begin
            take_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        utc_fields_t  got;
        dated_stamp_t want;
        if (rst_n)
        begin
            if (stamp_ch.valid && stamp_ch.ready)
            begin
                expected_dates.push_back({stamp_ch.epoch_seconds,
                                          utc_date_of(stamp_ch.epoch_seconds)});
            end
            if (date_ch.valid && date_ch.ready)
            begin
                got.second_of_minute = date_ch.second_of_minute;
                got.minute_of_hour   = date_ch.minute_of_hour;
                got.hour_of_day      = date_ch.hour_of_day;
                got.day_of_month     = date_ch.day_of_month;
                got.month_number     = date_ch.month_number;
                got.calendar_year    = date_ch.calendar_year;
                got.day_of_week      = date_ch.day_of_week;
                if (expected_dates.size() == 0)
                begin
                    note_failure($sformatf("unexpected result word %p", got));
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (got !== want.fields)
                    begin
                        note_failure($sformatf("stamp %0d: expected %p, got %p",
                                               want.stamp, want.fields, got));
                    end
                end
            end
            if ((stamp_ch.valid && stamp_ch.ready) || (date_ch.valid && date_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (EDGE_STAMPS[i])
        begin
            pending_stamps.push_back(EDGE_STAMPS[i]);
        end
        wait_drained();

        queue_random_stamps(PHASE_WORDS);
        wait_drained();

        sender_idle_pct = 67;
        queue_random_stamps(PHASE_WORDS);
        wait_drained();

        sender_idle_pct = 0;
        receiver_stall_pct = 67;
        queue_random_stamps(PHASE_WORDS);
        wait_drained();

        sender_idle_pct = 12;
        receiver_stall_pct = 12;
        queue_random_stamps(PHASE_WORDS);
        wait_drained();

        // long output stall while the sender keeps offering
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_request = 1'b1;
        queue_random_stamps(PRESSURE_WORDS);
        wait (hold_left != 0);
        hold_request = 1'b0;
        wait_drained();

        repeat (2 * etsud_pkg::LATENCY) @(posedge clk);
        if (expected_dates.size() != 0)
        begin
            note_failure($sformatf("%0d result words never arrived", expected_dates.size()));
        end
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/etsud_pkg.sv
src/etsud_if.sv
src/etsud_day_split.sv
src/etsud_clock.sv
src/etsud_date.sv
src/epoch_seconds_to_utc_date.sv
tb/epoch_seconds_to_utc_date_tb.sv
